// ===== rtl/ctok_pkg.sv =====
// ctok_pkg: shared types, codes and byte-class helpers for the C token scanner.
// No dependencies; used by ctok_step, c_token_scanner, ctok_checker and c_token_scanner_tb.
package ctok_pkg;

    // token kind codes
    localparam logic [1:0] KIND_STRING = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_NUMBER = 2'd2;
    localparam logic [1:0] KIND_IDENT  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_START = 2'd1;
    localparam logic [1:0] ERR_EOT_LIT   = 2'd2;

    // special bytes
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [9:0] {
        S_START   = 10'b00_0000_0001,
        S_STR     = 10'b00_0000_0010,
        S_STR_ESC = 10'b00_0000_0100,
        S_CHR     = 10'b00_0000_1000,
        S_CHR_ESC = 10'b00_0001_0000,
        S_ZERO    = 10'b00_0010_0000,
        S_HEX     = 10'b00_0100_0000,
        S_OCT     = 10'b00_1000_0000,
        S_DEC     = 10'b01_0000_0000,
        S_IDENT   = 10'b10_0000_0000
    } t_scan_state;

    typedef struct packed {
        logic       ended_before;
        logic [1:0] ended_kind;
        logic       in_token;
        logic [1:0] token_kind;
        logic       closes_token;
        logic [1:0] error_code;
    } t_scan_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_alpha_us(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

endpackage

// ===== rtl/ctok_step.sv =====
// ctok_step: next-state and result logic for one item of the token scanner.
// Purely combinational; depends on ctok_pkg.
module ctok_step (
    input  ctok_pkg::t_scan_state  i_state,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_end_of_text,
    output ctok_pkg::t_scan_state  o_next_state,
    output ctok_pkg::t_scan_result o_result
);
    import ctok_pkg::*;

    logic       start_new;   // byte starts a fresh token
    logic       ends_tok;    // a number or identifier ends before this byte
    logic [1:0] end_kind;

    always_comb begin
        o_result     = '0;
        o_next_state = S_START;
        start_new    = 1'b0;
        ends_tok     = 1'b0;
        end_kind     = KIND_NUMBER;

        if (i_end_of_text) begin
            unique case (i_state)
                S_STR, S_STR_ESC, S_CHR, S_CHR_ESC: begin
                    o_result.error_code = ERR_EOT_LIT;
                end
                S_ZERO, S_HEX, S_OCT, S_DEC: begin
                    o_result.ended_before = 1'b1;
                    o_result.ended_kind   = KIND_NUMBER;
                end
                S_IDENT: begin
                    o_result.ended_before = 1'b1;
                    o_result.ended_kind   = KIND_IDENT;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (i_state)
                S_STR, S_CHR: begin
                    o_result.in_token   = 1'b1;
                    o_result.token_kind = (i_state == S_STR) ? KIND_STRING : KIND_CHAR;
                    if (i_data_byte == ((i_state == S_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                        o_result.closes_token = 1'b1;
                        o_next_state          = S_START;
                    end else if (i_data_byte == CH_BSLASH) begin
                        o_next_state = (i_state == S_STR) ? S_STR_ESC : S_CHR_ESC;
                    end else begin
                        o_next_state = i_state;
                    end
                end
                S_STR_ESC: begin
                    o_result.in_token   = 1'b1;
                    o_result.token_kind = KIND_STRING;
                    o_next_state        = S_STR;
                end
                S_CHR_ESC: begin
                    o_result.in_token   = 1'b1;
                    o_result.token_kind = KIND_CHAR;
                    o_next_state        = S_CHR;
                end
                S_ZERO: begin
                    if (i_data_byte == CH_LOW_X) begin
                        o_next_state = S_HEX;
                    end else if (is_oct(i_data_byte)) begin
                        o_next_state = S_OCT;
                    end else begin
                        ends_tok = 1'b1;
                    end
                end
                S_HEX: begin
                    if (is_hex(i_data_byte)) o_next_state = S_HEX;
                    else ends_tok = 1'b1;
                end
                S_OCT: begin
                    if (is_oct(i_data_byte)) o_next_state = S_OCT;
                    else ends_tok = 1'b1;
                end
                S_DEC: begin
                    if (is_digit(i_data_byte)) o_next_state = S_DEC;
                    else ends_tok = 1'b1;
                end
                S_IDENT: begin
                    end_kind = KIND_IDENT;
                    if (is_alpha_us(i_data_byte) || is_digit(i_data_byte)) begin
                        o_next_state = S_IDENT;
                    end else begin
                        ends_tok = 1'b1;
                    end
                end
                default: begin
                    start_new = 1'b1;
                end
            endcase

            // number or identifier carries on with this byte
            if (!ends_tok && !start_new && (o_next_state == S_HEX || o_next_state == S_OCT
                    || o_next_state == S_DEC || o_next_state == S_IDENT)) begin
                o_result.in_token   = 1'b1;
                o_result.token_kind = (o_next_state == S_IDENT) ? KIND_IDENT : KIND_NUMBER;
            end

            if (ends_tok || start_new) begin
                o_result.ended_before = ends_tok;
                o_result.ended_kind   = ends_tok ? end_kind : KIND_STRING;
                o_result.in_token     = 1'b1;
                priority if (i_data_byte == CH_DQUOTE) begin
                    o_result.token_kind = KIND_STRING;
                    o_next_state        = S_STR;
                end else if (i_data_byte == CH_SQUOTE) begin
                    o_result.token_kind = KIND_CHAR;
                    o_next_state        = S_CHR;
                end else if (i_data_byte == CH_ZERO) begin
                    o_result.token_kind = KIND_NUMBER;
                    o_next_state        = S_ZERO;
                end else if (is_digit(i_data_byte)) begin
                    o_result.token_kind = KIND_NUMBER;
                    o_next_state        = S_DEC;
                end else if (is_alpha_us(i_data_byte)) begin
                    o_result.token_kind = KIND_IDENT;
                    o_next_state        = S_IDENT;
                end else begin
                    // bad start byte is dropped
                    o_result.in_token   = 1'b0;
                    o_result.token_kind = KIND_STRING;
                    o_result.error_code = ERR_BAD_START;
                    o_next_state        = S_START;
                end
            end
        end
    end

endmodule

// ===== rtl/c_token_scanner.sv =====
// c_token_scanner: one result per byte; o_out_valid rises the cycle after input accept.
// Throughput 1 item per cycle unless stalled; state and result update on every accept.
// o_in_ready is high while the result register is empty or being taken in the same cycle.
// Synchronous active-low reset returns the scanner to token start and empties the result.
// Depends on ctok_pkg and ctok_step.
module c_token_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_ended_before,
    output logic [1:0] o_ended_kind,
    output logic       o_in_token,
    output logic [1:0] o_token_kind,
    output logic       o_closes_token,
    output logic [1:0] o_error_code
);
    import ctok_pkg::*;

    t_scan_state  r_state;
    t_scan_state  n_state;
    t_scan_result r_result;
    t_scan_result n_result;
    logic         r_out_valid;
    logic         in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    ctok_step u_step (
        .i_state       (r_state),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_next_state  (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_START;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ended_before = r_result.ended_before;
    assign o_ended_kind   = r_result.ended_kind;
    assign o_in_token     = r_result.in_token;
    assign o_token_kind   = r_result.token_kind;
    assign o_closes_token = r_result.closes_token;
    assign o_error_code   = r_result.error_code;

endmodule

// ===== rtl/ctok_checker.sv =====
// ctok_checker: port-level assertions for c_token_scanner, attached by bind.
// Depends on ctok_pkg.
module ctok_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_end_of_text,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_ended_before,
    input logic [1:0] o_ended_kind,
    input logic       o_in_token,
    input logic [1:0] o_token_kind,
    input logic       o_closes_token,
    input logic [1:0] o_error_code
);
    import ctok_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted item produced no result");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result is stalled");

    a_eot_error_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_end_of_text) |=> (o_error_code != ERR_EOT_LIT))
        else $error("end-in-literal error on a data byte");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_ended_before)
            && $stable(o_ended_kind) && $stable(o_in_token) && $stable(o_token_kind)
            && $stable(o_closes_token) && $stable(o_error_code)))
        else $error("stalled result changed");

endmodule

bind c_token_scanner ctok_checker u_ctok_checker (.*);

// ===== tb/sv/c_token_scanner_tb.sv =====
// c_token_scanner_tb: self-checking bench for the C token scanner, one result per byte.
// Directed rows then random token streams, checked against an in-bench lexer model.
// Depends on ctok_pkg and the c_token_scanner RTL.
module c_token_scanner_tb;
    import ctok_pkg::*;

    localparam int unsigned TOTAL_ITEMS    = 1450;
    localparam int unsigned HOLD_AT_ITEM   = 600;
    localparam int unsigned QUIET_AT_ITEM  = 1250;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned REPORT_MAX     = 10;

    typedef enum logic [3:0] {
        SC_IDLE, SC_STR, SC_STR_ESC, SC_CHR, SC_CHR_ESC,
        SC_ZERO, SC_HEX, SC_OCT, SC_DEC, SC_WORD
    } t_lex_state;

    typedef struct packed {
        logic [7:0]   data;
        logic         eot;
        logic         pinned;
        t_scan_result want;
    } t_row;

    // results that can be read straight off the scanner rules
    localparam t_scan_result R_QUIET     = '0;
    localparam t_scan_result R_BAD       = '{1'b0, KIND_STRING, 1'b0, KIND_STRING, 1'b0,
                                             ERR_BAD_START};
    localparam t_scan_result R_STR_OPEN  = '{1'b0, KIND_STRING, 1'b1, KIND_STRING, 1'b0,
                                             ERR_NONE};
    localparam t_scan_result R_STR_CLOSE = '{1'b0, KIND_STRING, 1'b1, KIND_STRING, 1'b1,
                                             ERR_NONE};
    localparam t_scan_result R_LIT_EOT   = '{1'b0, KIND_STRING, 1'b0, KIND_STRING, 1'b0,
                                             ERR_EOT_LIT};
    localparam t_scan_result R_CHR_CLOSE = '{1'b0, KIND_STRING, 1'b1, KIND_CHAR, 1'b1,
                                             ERR_NONE};
    localparam t_scan_result R_NUM_IDENT = '{1'b1, KIND_NUMBER, 1'b1, KIND_IDENT, 1'b0,
                                             ERR_NONE};
    localparam t_scan_result R_IDENT_EOT = '{1'b1, KIND_IDENT, 1'b0, KIND_STRING, 1'b0,
                                             ERR_NONE};
    localparam t_scan_result R_NUM_EOT   = '{1'b1, KIND_NUMBER, 1'b0, KIND_STRING, 1'b0,
                                             ERR_NONE};

    localparam int unsigned DIR_ROWS = 29;
    localparam t_row DIRECTED [0:DIR_ROWS-1] = '{
        '{8'hA5,     1'b1, 1'b1, R_QUIET},      // end of text at token start
        '{8'h00,     1'b0, 1'b1, R_BAD},
        '{8'hFF,     1'b0, 1'b1, R_BAD},
        '{CH_DQUOTE, 1'b0, 1'b1, R_STR_OPEN},
        '{CH_DQUOTE, 1'b0, 1'b1, R_STR_CLOSE},  // empty string
        '{CH_DQUOTE, 1'b0, 1'b0, R_QUIET},
        '{CH_BSLASH, 1'b0, 1'b0, R_QUIET},
        '{CH_DQUOTE, 1'b0, 1'b0, R_QUIET},      // escaped quote stays inside
        '{8'h00,     1'b1, 1'b1, R_LIT_EOT},
        '{CH_SQUOTE, 1'b0, 1'b0, R_QUIET},
        '{8'h00,     1'b1, 1'b1, R_LIT_EOT},
        '{CH_SQUOTE, 1'b0, 1'b0, R_QUIET},
        '{CH_BSLASH, 1'b0, 1'b0, R_QUIET},
        '{8'hFF,     1'b1, 1'b1, R_LIT_EOT},    // end right after the escape
        '{CH_SQUOTE, 1'b0, 1'b0, R_QUIET},
        '{CH_SQUOTE, 1'b0, 1'b1, R_CHR_CLOSE},
        '{CH_ZERO,   1'b0, 1'b0, R_QUIET},
        '{CH_LOW_X,  1'b0, 1'b0, R_QUIET},
        '{8'h46,     1'b0, 1'b0, R_QUIET},
        '{8'h67,     1'b0, 1'b1, R_NUM_IDENT},  // 'g' ends hex, starts a name
        '{8'h5F,     1'b0, 1'b0, R_QUIET},
        '{8'h39,     1'b0, 1'b0, R_QUIET},
        '{8'h00,     1'b1, 1'b1, R_IDENT_EOT},
        '{CH_ZERO,   1'b0, 1'b0, R_QUIET},
        '{8'h37,     1'b0, 1'b0, R_QUIET},
        '{8'h38,     1'b0, 1'b0, R_QUIET},      // '8' ends octal, starts decimal
        '{8'h20,     1'b0, 1'b0, R_QUIET},      // ends decimal and is a bad start
        '{CH_ZERO,   1'b0, 1'b0, R_QUIET},
        '{8'h00,     1'b1, 1'b1, R_NUM_EOT}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_ended_before;
    logic [1:0] o_ended_kind;
    logic       o_in_token;
    logic [1:0] o_token_kind;
    logic       o_closes_token;
    logic [1:0] o_error_code;

    // typed-in expectation travels with the item, driven like the payload
    logic         pin_valid = 1'b0;
    t_scan_result pin_value = '0;

    t_lex_state   lex_st = SC_IDLE;
    t_scan_result due_results [$];
    logic [8:0]   byte_feed [$];

    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned items_seen = 0;
    int unsigned results_checked = 0;
    int unsigned tokens_ended = 0;
    int unsigned bad_starts = 0;
    int unsigned lit_cuts = 0;
    int unsigned stuck_cycles = 0;

    c_token_scanner u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ended_before (o_ended_before),
        .o_ended_kind   (o_ended_kind),
        .o_in_token     (o_in_token),
        .o_token_kind   (o_token_kind),
        .o_closes_token (o_closes_token),
        .o_error_code   (o_error_code)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic in_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic in_oct(input logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic logic in_hex(input logic [7:0] c);
        return in_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic in_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // lexer model: classifies one item and advances lex_st
    function automatic t_scan_result lex_byte(input logic [7:0] c, input logic eot);
        t_scan_result r;
        logic         keep;
        logic         was_num;
        r = '0;
        keep = 1'b0;
        if (eot) begin
            case (lex_st)
                SC_STR, SC_STR_ESC, SC_CHR, SC_CHR_ESC: r.error_code = ERR_EOT_LIT;
                SC_ZERO, SC_HEX, SC_OCT, SC_DEC: begin
                    r.ended_before = 1'b1;
                    r.ended_kind = KIND_NUMBER;
                end
                SC_WORD: begin
                    r.ended_before = 1'b1;
                    r.ended_kind = KIND_IDENT;
                end
                default: ;
            endcase
            lex_st = SC_IDLE;
            return r;
        end
        case (lex_st)
            SC_STR, SC_CHR: begin
                keep = 1'b1;
                r.in_token = 1'b1;
                r.token_kind = (lex_st == SC_STR) ? KIND_STRING : KIND_CHAR;
                if (c == ((lex_st == SC_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                    r.closes_token = 1'b1;
                    lex_st = SC_IDLE;
                end else if (c == CH_BSLASH) begin
                    lex_st = (lex_st == SC_STR) ? SC_STR_ESC : SC_CHR_ESC;
                end
            end
            SC_STR_ESC: begin
                keep = 1'b1;
                r.in_token = 1'b1;
                r.token_kind = KIND_STRING;
                lex_st = SC_STR;
            end
            SC_CHR_ESC: begin
                keep = 1'b1;
                r.in_token = 1'b1;
                r.token_kind = KIND_CHAR;
                lex_st = SC_CHR;
            end
            SC_ZERO: begin
                if (c == CH_LOW_X) begin
                    keep = 1'b1;
                    lex_st = SC_HEX;
                end else if (in_oct(c)) begin
                    keep = 1'b1;
                    lex_st = SC_OCT;
                end
            end
            SC_HEX: keep = in_hex(c);
            SC_OCT: keep = in_oct(c);
            SC_DEC: keep = in_dec(c);
            SC_WORD: keep = in_word(c) || in_dec(c);
            default: ;
        endcase
        was_num = lex_st inside {SC_ZERO, SC_HEX, SC_OCT, SC_DEC};
        if (keep && (was_num || lex_st == SC_WORD)) begin
            r.in_token = 1'b1;
            r.token_kind = was_num ? KIND_NUMBER : KIND_IDENT;
        end
        if (!keep) begin
            // this byte is not part of the running token: it starts the next one
            if (was_num || lex_st == SC_WORD) begin
                r.ended_before = 1'b1;
                r.ended_kind = was_num ? KIND_NUMBER : KIND_IDENT;
            end
            r.in_token = 1'b1;
            if (c == CH_DQUOTE) begin
                r.token_kind = KIND_STRING;
                lex_st = SC_STR;
            end else if (c == CH_SQUOTE) begin
                r.token_kind = KIND_CHAR;
                lex_st = SC_CHR;
            end else if (c == CH_ZERO) begin
                r.token_kind = KIND_NUMBER;
                lex_st = SC_ZERO;
            end else if (in_dec(c)) begin
                r.token_kind = KIND_NUMBER;
                lex_st = SC_DEC;
            end else if (in_word(c)) begin
                r.token_kind = KIND_IDENT;
                lex_st = SC_WORD;
            end else begin
                r.in_token = 1'b0;
                r.token_kind = KIND_STRING;
                r.error_code = ERR_BAD_START;
                lex_st = SC_IDLE;
            end
        end
        return r;
    endfunction

    function automatic string show(input t_scan_result r);
        return $sformatf("ended=%0d ekind=%0d in_tok=%0d tkind=%0d close=%0d err=%0d",
                         r.ended_before, r.ended_kind, r.in_token, r.token_kind,
                         r.closes_token, r.error_code);
    endfunction

    function automatic string diff_fields(input t_scan_result w, input t_scan_result g);
        string s;
        s = "";
        if (w.ended_before !== g.ended_before) s = {s, " ended_before"};
        if (w.ended_kind !== g.ended_kind) s = {s, " ended_kind"};
        if (w.in_token !== g.in_token) s = {s, " in_token"};
        if (w.token_kind !== g.token_kind) s = {s, " token_kind"};
        if (w.closes_token !== g.closes_token) s = {s, " closes_token"};
        if (w.error_code !== g.error_code) s = {s, " error_code"};
        return s;
    endfunction

    function automatic void log_fault(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // result check first: the result is registered, so an output never
    // belongs to the item taken at the same edge
    always @(posedge i_clk) begin
        t_scan_result got;
        t_scan_result want;
        t_scan_result guess;
        string        bad;
        logic         in_acc;
        logic         out_acc;
        in_acc = i_rst_n && i_in_valid && o_in_ready;
        out_acc = i_rst_n && o_out_valid && i_out_ready;
        if (out_acc) begin
            got = {o_ended_before, o_ended_kind, o_in_token, o_token_kind,
                   o_closes_token, o_error_code};
            if (due_results.size() == 0) begin
                log_fault({"result with nothing pending: ", show(got)});
            end else begin
                want = due_results.pop_front();
                bad = diff_fields(want, got);
                if (bad != "")
                    log_fault($sformatf("result %0d wrong in%s\n  want %s\n  got  %s",
                                        results_checked, bad, show(want), show(got)));
                results_checked++;
            end
        end
        if (in_acc) begin
            guess = lex_byte(i_data_byte, i_end_of_text);
            due_results.push_back(pin_valid ? pin_value : guess);
            items_seen++;
            if (guess.ended_before) tokens_ended++;
            if (guess.error_code == ERR_BAD_START) bad_starts++;
            if (guess.error_code == ERR_EOT_LIT) lit_cuts++;
        end
        stuck_cycles = (in_acc || out_acc) ? 0 : stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     stuck_cycles, due_results.size());
            $display("c_token_scanner verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eot, input logic pin,
                             input t_scan_result pinv);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_text <= eot;
        pin_valid <= pin;
        pin_value <= pinv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic void feed(input logic eot, input logic [7:0] b);
        byte_feed.push_back({eot, b});
    endfunction

    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // one random chunk: mostly well-formed tokens, some separators, cuts and noise
    function automatic void queue_chunk();
        int unsigned pick;
        int unsigned sub;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 9);
        if (pick < 32) begin
            // string or char literal with arbitrary body bytes
            b = (pick < 20) ? CH_DQUOTE : CH_SQUOTE;
            feed(1'b0, b);
            repeat ((pick < 20) ? $urandom_range(0, 6) : 1) begin
                logic [7:0] body;
                body = 8'($urandom_range(0, 255));
                if (body == b || body == CH_BSLASH || $urandom_range(0, 7) == 0)
                    feed(1'b0, CH_BSLASH);
                feed(1'b0, body);
            end
            if (sub == 0) begin
                if ($urandom_range(0, 1)) feed(1'b0, CH_BSLASH);
                feed(1'b1, 8'($urandom_range(0, 255)));
            end else begin
                feed(1'b0, b);
            end
        end else if (pick < 52) begin
            if (sub < 3) begin
                feed(1'b0, CH_ZERO);
                feed(1'b0, CH_LOW_X);
                repeat ($urandom_range(0, 4)) feed(1'b0, pick_from("0123456789abcdefABCDEF"));
            end else if (sub < 5) begin
                feed(1'b0, CH_ZERO);
                repeat ($urandom_range(0, 3)) feed(1'b0, pick_from("01234567"));
            end else begin
                feed(1'b0, pick_from("123456789"));
                repeat ($urandom_range(0, 4)) feed(1'b0, pick_from("0123456789"));
            end
        end else if (pick < 72) begin
            feed(1'b0, pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
            repeat ($urandom_range(0, 6))
                feed(1'b0, pick_from("abcxyzABCXYZ_0123456789"));
        end else if (pick < 84) begin
            feed(1'b0, pick_from(" \t\n,;(){}+-*/=<>.!#"));
        end else if (pick < 92) begin
            feed(1'b1, 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 3))
                feed($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
        end
    endfunction

    initial begin
        logic [8:0] entry;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].data, DIRECTED[i].eot, DIRECTED[i].pinned,
                      DIRECTED[i].want);

        while (items_sent < TOTAL_ITEMS) begin
            if (byte_feed.size() == 0) queue_chunk();
            entry = byte_feed.pop_front();
            send_item(entry[7:0], entry[8], 1'b0, R_QUIET);
            if (items_sent == HOLD_AT_ITEM) hold_req = 1'b1;
            if (items_sent == QUIET_AT_ITEM) idle_on = 1'b0;
        end
        i_in_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered: %0d items scanned, %0d results compared, %0d bad start bytes",
                 items_seen, results_checked, bad_starts);
        $display("         %0d number/name tokens ended, %0d literals cut by end of text",
                 tokens_ended, lit_cuts);
        if (fail_count == 0) begin
            $display("c_token_scanner verification clean");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("c_token_scanner verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ctok_pkg.sv
rtl/ctok_step.sv
rtl/c_token_scanner.sv
rtl/ctok_checker.sv
tb/sv/c_token_scanner_tb.sv
